### rtl/core/tlb_page_table_translator_assert.svh
// ----------------------------------------------------------------------------
// tlb page table translator assertion macros
// implication checks on the core clock, disabled while reset is held
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TLBPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlbpt assertion failed");

// next-cycle implication
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlbpt assertion failed");

`else

`define TLBPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// shared widths, defaults and inter-module structs of the address translator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlbpt_pkg;

    // field widths
    localparam int ADDR_W   = 16;
    localparam int PAGE_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int FRAME_W  = 8;
    localparam int HITS_W   = 32;
    localparam int COUNT_W  = 9;

    // parameter defaults
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int PAGE_BYTES_DEF  = 256;

    // tlb install command
    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_tlb_fill;

    // tlb lookup result, valid the cycle after the lookup
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_result;

    // page table mapping write
    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_pt_update;

    // page table read result, valid the cycle after the read
    typedef struct packed {
        logic               mapped;
        logic [FRAME_W-1:0] frame;
    } t_pt_result;

endpackage

### rtl/core/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// tlbpt_tlb
// fully associative tlb: tag and valid flops for the parallel compare, frame
// store in a registered-read memory, fifo replacement pointer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlbpt_tlb #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_look_en,
    input  logic [tlbpt_pkg::PAGE_W-1:0]   i_look_page,
    input  tlbpt_pkg::t_tlb_fill           i_fill,
    output tlbpt_pkg::t_tlb_result         o_result
);

    localparam int TIDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [tlbpt_pkg::PAGE_W-1:0]  r_tag       [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]        r_valid;
    logic [tlbpt_pkg::FRAME_W-1:0] r_frame_mem [TLB_ENTRIES];
    logic [TIDX_W-1:0]             r_ptr;
    logic [TIDX_W-1:0]             n_ptr;
    logic                          r_hit;
    logic [tlbpt_pkg::FRAME_W-1:0] r_rd_frame;
    logic                          w_match;
    logic [TIDX_W-1:0]             w_idx;

    // parallel tag compare, lowest matching entry wins
    always_comb begin
        w_match = 1'b0;
        w_idx   = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == i_look_page)) begin
                w_match = 1'b1;
                w_idx   = TIDX_W'(i);
            end
        end
    end

    // fifo pointer wraps at the entry count
    always_comb begin
        if (r_ptr == TIDX_W'(TLB_ENTRIES - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_look_en) begin
                r_hit <= w_match;
            end
            if (i_fill.en) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= n_ptr;
            end
        end
    end

    // tags and frame memory
    always_ff @(posedge i_clk) begin
        if (i_look_en) begin
            r_rd_frame <= r_frame_mem[w_idx];
        end
        if (i_fill.en) begin
            r_tag[r_ptr]       <= i_fill.page;
            r_frame_mem[r_ptr] <= i_fill.frame;
        end
    end

    assign o_result.hit   = r_hit;
    assign o_result.frame = r_rd_frame;

endmodule

### rtl/core/tlbpt_page_table.sv
// ----------------------------------------------------------------------------
// tlbpt_page_table
// page table: frame numbers in a registered-read memory, mapped bits in flops
// cleared at reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlbpt_page_table #(
    parameter int PAGE_COUNT = tlbpt_pkg::PAGE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [tlbpt_pkg::PAGE_W-1:0] i_rd_page,
    input  tlbpt_pkg::t_pt_update        i_update,
    output tlbpt_pkg::t_pt_result        o_result
);

    localparam int PIDX_W = $clog2(PAGE_COUNT);

    logic [PAGE_COUNT-1:0]         r_valid;
    logic [tlbpt_pkg::FRAME_W-1:0] r_mem [PAGE_COUNT];
    logic                          r_mapped;
    logic [tlbpt_pkg::FRAME_W-1:0] r_rd_frame;
    logic [PIDX_W-1:0]             w_rd_idx;
    logic [PIDX_W-1:0]             w_wr_idx;

    assign w_rd_idx = i_rd_page[PIDX_W-1:0];
    assign w_wr_idx = i_update.page[PIDX_W-1:0];

    // mapped bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_mapped <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_mapped <= r_valid[w_rd_idx];
            end
            if (i_update.en) begin
                r_valid[w_wr_idx] <= 1'b1;
            end
        end
    end

    // frame memory
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_frame <= r_mem[w_rd_idx];
        end
        if (i_update.en) begin
            r_mem[w_wr_idx] <= i_update.frame;
        end
    end

    assign o_result.mapped = r_mapped;
    assign o_result.frame  = r_rd_frame;

endmodule

### rtl/core/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// flow: address captured on accept, tlb and page table read in the look
//   state, result registered on leaving the resolve state; a new address is
//   taken only while idle or as the last one resolves, which an output stall holds
// reset: synchronous, clears tlb valid bits, page mapped bits, fifo pointer,
//   free frame and counters; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tlb_page_table_translator_assert.svh"

module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0]  i_logical_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tlbpt_pkg::ADDR_W-1:0]  o_physical_address,
    output logic                          o_tlb_hit,
    output logic                          o_page_fault,
    output logic [tlbpt_pkg::HITS_W-1:0]  o_hits_total,
    output logic [tlbpt_pkg::COUNT_W-1:0] o_faults_total
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_LOOK    = 3'b010,
        S_RESOLVE = 3'b100
    } t_state;

    localparam int PW = tlbpt_pkg::PAGE_W;
    localparam int FW = tlbpt_pkg::FRAME_W;
    localparam int AW = tlbpt_pkg::ADDR_W;
    localparam int RW = 2 * PW;

    t_state                        r_state;
    t_state                        n_state;
    logic [PW-1:0]                 r_page;
    logic [tlbpt_pkg::OFFSET_W-1:0] r_offset;
    logic [tlbpt_pkg::COUNT_W-1:0] r_free_next;
    logic [tlbpt_pkg::COUNT_W-1:0] r_faults;
    logic [tlbpt_pkg::HITS_W-1:0]  r_hits;
    logic                          r_out_valid;
    logic [AW-1:0]                 r_out_addr;
    logic                          r_out_hit;
    logic                          r_out_fault;

    logic                          w_in_accept;
    logic                          w_resolve_go;
    logic                          w_look_en;
    logic [PW-1:0]                 w_page;
    logic                          w_fault;
    logic [FW-1:0]                 w_frame;
    logic [AW-1:0]                 w_base;
    logic [AW:0]                   w_phys;

    tlbpt_pkg::t_tlb_fill          w_fill;
    tlbpt_pkg::t_tlb_result        w_tlb;
    tlbpt_pkg::t_pt_update         w_pt_upd;
    tlbpt_pkg::t_pt_result         w_pt;

    // page number reduced modulo the table size, restoring compare/subtract
    always_comb begin
        logic [RW-1:0] v;
        v = RW'(i_logical_address[AW-1:tlbpt_pkg::OFFSET_W]);
        for (int k = PW - 1; k >= 0; k--) begin
            if (v >= (RW'(PAGE_COUNT) << k)) begin
                v = v - (RW'(PAGE_COUNT) << k);
            end
        end
        w_page = v[PW-1:0];
    end

    // handshake
    assign w_resolve_go = (r_state == S_RESOLVE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall   = !((r_state == S_IDLE) || w_resolve_go);
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_look_en    = (r_state == S_LOOK);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (w_resolve_go) begin
                    n_state = w_in_accept ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // frame selection and write-back commands
    always_comb begin
        w_fault = !w_tlb.hit && !w_pt.mapped;
        if (w_tlb.hit) begin
            w_frame = w_tlb.frame;
        end else if (w_pt.mapped) begin
            w_frame = w_pt.frame;
        end else begin
            w_frame = r_free_next[FW-1:0];
        end
        w_fill.en      = w_resolve_go && !w_tlb.hit;
        w_fill.page    = r_page;
        w_fill.frame   = w_frame;
        w_pt_upd.en    = w_resolve_go && w_fault;
        w_pt_upd.page  = r_page;
        w_pt_upd.frame = r_free_next[FW-1:0];
    end

    // physical address, wraps to address width
    assign w_base = AW'(w_frame) * AW'(PAGE_BYTES);
    assign w_phys = {1'b0, w_base} + (AW + 1)'(r_offset);

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_next <= '0;
            r_faults    <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_resolve_go) begin
                r_out_valid <= 1'b1;
                if (w_tlb.hit) begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + 1'b1;
                    end
                end else if (w_fault) begin
                    r_free_next <= r_free_next + 1'b1;
                    r_faults    <= r_faults + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // address capture and result beat
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_page   <= w_page;
            r_offset <= i_logical_address[tlbpt_pkg::OFFSET_W-1:0];
        end
        if (w_resolve_go) begin
            r_out_addr  <= w_phys[AW-1:0];
            r_out_hit   <= w_tlb.hit;
            r_out_fault <= w_fault;
        end
    end

    tlbpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_tlb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_look_en   (w_look_en),
        .i_look_page (r_page),
        .i_fill      (w_fill),
        .o_result    (w_tlb)
    );

    tlbpt_page_table #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_page_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_look_en),
        .i_rd_page (r_page),
        .i_update  (w_pt_upd),
        .o_result  (w_pt)
    );

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_out_addr;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_hits_total       = r_hits;
    assign o_faults_total     = r_faults;

    // checks
    `TLBPT_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, w_in_accept, r_state == S_LOOK)
    `TLBPT_ASSERT_IMPLY(a_faults_track_frames, i_clk, i_rst_n, 1'b1, r_faults == r_free_next)
    `TLBPT_ASSERT_IMPLY(a_hit_not_fault, i_clk, i_rst_n, r_out_valid, !(r_out_hit && r_out_fault))
    `TLBPT_ASSERT_NEXT(a_fault_counts, i_clk, i_rst_n, w_resolve_go && w_fault, r_faults == $past(r_faults) + 1'b1)

endmodule

### dv/tlb_page_table_translator_test.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_test
// drives logical addresses through the translator and checks every result
// beat against a cycle-free model of the tlb, the demand-paged page table and
// the running totals; runs directed corner addresses, then locality-shaped
// random traffic under several sender idle and receiver stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_page_table_translator_test;

    localparam int TLB_SLOTS   = tlbpt_pkg::TLB_ENTRIES_DEF;
    localparam int PAGE_SLOTS  = tlbpt_pkg::PAGE_COUNT_DEF;
    localparam int FRAME_BYTES = tlbpt_pkg::PAGE_BYTES_DEF;
    localparam int HOT_PAGES   = 20;
    localparam int PHASE_BEATS = 250;
    localparam int MAX_REPORTS = 10;

    // one translated address as seen on the result channel
    typedef struct {
        logic [tlbpt_pkg::ADDR_W-1:0]  phys;
        logic                          hit;
        logic                          fault;
        logic [tlbpt_pkg::HITS_W-1:0]  hits;
        logic [tlbpt_pkg::COUNT_W-1:0] faults;
    } t_translation;

    // model of tlb, page table and counters plus the expected result queue
    class t_translation_scoreboard;
        bit [tlbpt_pkg::PAGE_W-1:0]  tlb_tag [TLB_SLOTS];
        bit [tlbpt_pkg::FRAME_W-1:0] tlb_frm [TLB_SLOTS];
        bit                          tlb_vld [TLB_SLOTS];
        int unsigned                 fifo_ptr;
        bit [tlbpt_pkg::FRAME_W-1:0] pt_frame [PAGE_SLOTS];
        bit                          pt_mapped [PAGE_SLOTS];
        bit [tlbpt_pkg::COUNT_W-1:0] next_free;
        bit [tlbpt_pkg::HITS_W-1:0]  hit_count;
        bit [tlbpt_pkg::COUNT_W-1:0] fault_count;
        t_translation                expected_translations[$];
        int                          mismatches;

        // translate one accepted address and queue what the block must return
        function void note_address(logic [tlbpt_pkg::ADDR_W-1:0] addr);
            int unsigned  page;
            int unsigned  frame;
            int unsigned  slot;
            bit           hit;
            bit           fault;
            t_translation t;
            page  = addr[15:8] % PAGE_SLOTS;
            frame = 0;
            hit   = 1'b0;
            fault = 1'b0;
            // lowest matching valid entry wins
            for (int i = 0; i < TLB_SLOTS; i++) begin
                if (!hit && tlb_vld[i] && tlb_tag[i] == tlbpt_pkg::PAGE_W'(page)) begin
                    frame = tlb_frm[i];
                    hit   = 1'b1;
                end
            end
            if (hit) begin
                if (hit_count != '1) hit_count++;
            end else begin
                if (pt_mapped[page]) begin
                    frame = pt_frame[page];
                end else begin
                    // demand paging: hand out the next free frame
                    frame           = next_free[tlbpt_pkg::FRAME_W-1:0];
                    pt_frame[page]  = tlbpt_pkg::FRAME_W'(frame);
                    pt_mapped[page] = 1'b1;
                    next_free       = next_free + 1'b1;
                    fault_count     = fault_count + 1'b1;
                    fault           = 1'b1;
                end
                // fifo replacement
                slot          = fifo_ptr % TLB_SLOTS;
                tlb_tag[slot] = tlbpt_pkg::PAGE_W'(page);
                tlb_frm[slot] = tlbpt_pkg::FRAME_W'(frame);
                tlb_vld[slot] = 1'b1;
                fifo_ptr      = (slot + 1) % TLB_SLOTS;
            end
            t.phys   = tlbpt_pkg::ADDR_W'(frame * FRAME_BYTES + addr[7:0]);
            t.hit    = hit;
            t.fault  = fault;
            t.hits   = hit_count;
            t.faults = fault_count;
            expected_translations.push_back(t);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_translation(t_translation got);
            t_translation want;
            if (expected_translations.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result beat phys=%h", $realtime, got.phys);
                return;
            end
            want = expected_translations.pop_front();
            if (got.phys !== want.phys || got.hit !== want.hit || got.fault !== want.fault
                    || got.hits !== want.hits || got.faults !== want.faults) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch exp phys=%h hit=%b flt=%b hits=%0d flts=%0d",
                             $realtime, want.phys, want.hit, want.fault, want.hits,
                             want.faults, " got phys=%h hit=%b flt=%b hits=%0d flts=%0d",
                             got.phys, got.hit, got.fault, got.hits, got.faults);
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [tlbpt_pkg::ADDR_W-1:0]  i_logical_address = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [tlbpt_pkg::ADDR_W-1:0]  o_physical_address;
    logic                          o_tlb_hit;
    logic                          o_page_fault;
    logic [tlbpt_pkg::HITS_W-1:0]  o_hits_total;
    logic [tlbpt_pkg::COUNT_W-1:0] o_faults_total;

    t_translation_scoreboard       sb = new;
    int unsigned                   send_idle_pct = 0;
    int unsigned                   stall_pct = 0;
    logic [tlbpt_pkg::PAGE_W-1:0]  hot_page [HOT_PAGES];

    tlb_page_table_translator i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_logical_address  (i_logical_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_hits_total       (o_hits_total),
        .o_faults_total     (o_faults_total)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: sample the beat, then pick the next stall
    initial begin
        t_translation got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.phys   = o_physical_address;
                got.hit    = o_tlb_hit;
                got.fault  = o_page_fault;
                got.hits   = o_hits_total;
                got.faults = o_faults_total;
                sb.check_translation(got);
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // one address beat, with random idle cycles in front
    task automatic send_address(input logic [tlbpt_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_logical_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_address(addr);
    endtask

    // hold the sender until every queued result is back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (sb.expected_translations.size() != 0) @(posedge i_clk);
    endtask

    // mostly a working set a bit larger than the tlb, plus noise and set churn
    task automatic send_random_address();
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(99);
        idx  = $urandom_range(HOT_PAGES - 1);
        if (pick < 80) begin
            send_address({hot_page[idx], 8'($urandom)});
        end else if (pick < 90) begin
            send_address(16'($urandom));
        end else begin
            hot_page[idx] = 8'($urandom);
            send_address({hot_page[idx], 8'($urandom)});
        end
    endtask

    initial begin
        int unsigned idle_mix  [4];
        int unsigned stall_mix [4];
        int          guard;
        idle_mix  = '{0, 57, 0, 26};
        stall_mix = '{0, 0, 57, 26};
        foreach (hot_page[i]) hot_page[i] = 8'($urandom);

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: offset and page extremes, first fault, hit on same page
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'hAA55);
        send_address(16'h55AA);
        // fill the rest of the tlb, then wrap the fifo pointer
        for (int p = 1; p <= 12; p++) send_address({8'(p), 8'(p * 17)});
        send_address(16'h1380);
        // evicted pages come back from the page table without a fault
        send_address(16'h0042);
        send_address(16'hFF80);
        send_address(16'hAA00);
        wait_results_done();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_mix[ph];
            stall_pct     = stall_mix[ph];
            repeat (PHASE_BEATS) send_random_address();
            wait_results_done();
        end

        // drain
        i_in_valid <= 1'b0;
        stall_pct  = 0;
        guard      = 0;
        while (sb.expected_translations.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_translations.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### tlb_page_table_translator.f
+incdir+rtl/core
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_tlb.sv
rtl/core/tlbpt_page_table.sv
rtl/core/tlb_page_table_translator.sv
dv/tlb_page_table_translator_test.sv
